// ===== hdl/ptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg
// Request and status codes and fixed field widths of the preorder tree table.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int INDEX_W  = 6;
	localparam int COUNT_W  = 6;
	localparam int PARENT_W = 7;
	localparam int DATA_W   = 32;
	localparam int NODE_W   = 7;
	localparam int EXT_W    = 64;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

endpackage

// ===== hdl/preorder_tree_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preorder_tree_table
// Tree held as a depth-first ordered table with add, subtree delete and read.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_stall): kind, index, payload. A request is
// taken when req_valid is high and req_stall low; req_stall is high from the
// cycle after a request is taken until its result has been moved to the
// result register.
// Result channel (res_valid/res_stall): one result per request, held in an
// output register while res_stall is high. A new request is taken while an
// earlier result still waits there.
// Entries are moved through the single read/write port pair of the table
// memory, one entry moved per cycle: a read or a rejected request moves
// none, an add below parent p moves every entry after p up by one, and a
// delete of node d > 0 moves every entry after the subtree of d down over it.
// Reset empties the table (used count zero); entry contents are not cleared
// and no clearing pass is needed, as only entries below the count are read.
// ----------------------------------------------------------------------------
module preorder_tree_table #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          kind,
	input  logic [ptt_pkg::INDEX_W-1:0]         index,
	input  logic [ptt_pkg::DATA_W-1:0]          payload,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [1:0]                          status,
	output logic [ptt_pkg::INDEX_W-1:0]         position,
	output logic signed [ptt_pkg::PARENT_W-1:0] parent_index,
	output logic [ptt_pkg::COUNT_W-1:0]         child_count,
	output logic [ptt_pkg::DATA_W-1:0]          entry_data,
	output logic [ptt_pkg::NODE_W-1:0]          node_count
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int PW  = AW + 1;
	localparam int IW  = ptt_pkg::INDEX_W;
	localparam int NW  = ptt_pkg::NODE_W;
	localparam int KW  = ptt_pkg::COUNT_W;
	localparam int OPW = ptt_pkg::PARENT_W;
	localparam int XW  = (CW > IW) ? CW : IW;
	localparam int XPW = (PW > OPW) ? PW : OPW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_SHIFT,
		S_ADD_PARENT,
		S_ADD_NEW,
		S_DEL_HEAD,
		S_DEL_SCAN,
		S_DEL_MOVE,
		S_DEL_FIX_RD,
		S_DEL_FIX_WR,
		S_READ_WAIT,
		S_FINISH
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           used_q;
	ptt_pkg::kind_t          kind_q;
	logic [IW-1:0]           idx_q;
	logic [DATA_WIDTH-1:0]   pay_q;
	logic [AW-1:0]           base_q;
	logic [CW-1:0]           rd_ptr_q;
	logic                    pend_q;
	logic [CW-1:0]           pend_addr_q;
	logic signed [PW-1:0]    up_q;
	logic [CW-1:0]           span_q;
	ptt_pkg::status_t        hold_status_q;
	logic [IW-1:0]           hold_pos_q;
	logic signed [OPW-1:0]   hold_par_q;
	logic [KW-1:0]           hold_cnt_q;
	logic [ptt_pkg::DATA_W-1:0] hold_dat_q;
	ptt_pkg::status_t        status_q;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [AW-1:0]           mem_raddr;
	logic [PW-1:0]           w_par;
	logic [KW-1:0]           w_cnt;
	logic [DATA_WIDTH-1:0]   w_dat;
	logic [PW-1:0]           r_par;
	logic [KW-1:0]           rd_cnt;
	logic [DATA_WIDTH-1:0]   rd_dat;
	logic signed [PW-1:0]    rd_par;

	logic [ptt_pkg::EXT_W-1:0] pay_x;
	logic [ptt_pkg::EXT_W-1:0] rd_dat_x;
	logic signed [XPW-1:0]   rd_par_x;
	logic                    idx_ok;
	logic                    full;
	logic signed [PW-1:0]    base_s;
	logic [PW-1:0]           base_inc;
	logic                    add_more;
	logic                    fwd_more;
	logic                    scan_found;
	logic                    up_ok;

	ptt_pkg::status_t        dec_status;
	logic [IW-1:0]           dec_pos;
	state_t                  dec_state;

	ptt_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_parent_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (w_par),
		.raddr (mem_raddr),
		.rdata (r_par)
	);

	ptt_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_count_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (w_cnt),
		.raddr (mem_raddr),
		.rdata (rd_cnt)
	);

	ptt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_data_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (w_dat),
		.raddr (mem_raddr),
		.rdata (rd_dat)
	);

	assign rd_par     = $signed(r_par);
	assign pay_x      = ptt_pkg::EXT_W'(payload);
	assign rd_dat_x   = ptt_pkg::EXT_W'(rd_dat);
	assign rd_par_x   = XPW'(rd_par);
	assign idx_ok     = XW'(idx_q) < XW'(used_q);
	assign full       = used_q >= CW'(CAPACITY);
	assign base_s     = $signed(PW'(base_q));
	assign base_inc   = PW'(base_q) + 1'b1;
	assign add_more   = rd_ptr_q > CW'(base_q);
	assign fwd_more   = rd_ptr_q < used_q;
	assign scan_found = pend_q && (rd_par < base_s);
	assign up_ok      = !up_q[PW-1] && (CW'(up_q[AW-1:0]) < used_q);

	assign req_stall  = (state_q != S_IDLE);
	assign status     = status_q;

	always_comb begin
		dec_status = ptt_pkg::STATUS_OK;
		dec_pos    = idx_q;
		dec_state  = S_FINISH;
		unique case (kind_q)
			ptt_pkg::KIND_ADD: begin
				if (used_q == '0) begin
					dec_pos = '0;
				end else if (full) begin
					dec_status = ptt_pkg::STATUS_FULL;
				end else if (!idx_ok) begin
					dec_status = ptt_pkg::STATUS_RANGE;
				end else begin
					dec_state = S_ADD_SHIFT;
				end
			end
			ptt_pkg::KIND_DELETE: begin
				if (idx_q == '0) begin
				end else if (!idx_ok) begin
					dec_status = ptt_pkg::STATUS_RANGE;
				end else begin
					dec_state = S_DEL_HEAD;
				end
			end
			ptt_pkg::KIND_READ: begin
				if (!idx_ok) begin
					dec_status = ptt_pkg::STATUS_RANGE;
				end else begin
					dec_state = S_READ_WAIT;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_raddr = '0;
		w_par     = '0;
		w_cnt     = '0;
		w_dat     = '0;
		unique case (state_q)
			S_DECODE: begin
				mem_raddr = AW'(idx_q);
				if (kind_q == ptt_pkg::KIND_ADD && used_q == '0) begin
					mem_we = 1'b1;
					w_par  = '1;
					w_dat  = pay_q;
				end
			end
			S_ADD_SHIFT: begin
				mem_raddr = add_more ? AW'(rd_ptr_q) : base_q;
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pend_addr_q + 1'b1);
					w_par     = (rd_par > base_s) ? PW'(rd_par + 1'b1) : r_par;
					w_cnt     = rd_cnt;
					w_dat     = rd_dat;
				end
			end
			S_ADD_PARENT: begin
				mem_we    = 1'b1;
				mem_waddr = base_q;
				w_par     = r_par;
				w_cnt     = (rd_cnt < ptt_pkg::COUNT_MAX) ? KW'(rd_cnt + 1'b1) : rd_cnt;
				w_dat     = rd_dat;
			end
			S_ADD_NEW: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(base_inc);
				w_par     = PW'(base_q);
				w_dat     = pay_q;
			end
			S_DEL_SCAN: begin
				mem_raddr = AW'(rd_ptr_q);
			end
			S_DEL_MOVE: begin
				mem_raddr = AW'(rd_ptr_q);
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(pend_addr_q - span_q);
					w_par     = (rd_par > up_q) ? PW'(rd_par - $signed(PW'(span_q))) : r_par;
					w_cnt     = rd_cnt;
					w_dat     = rd_dat;
				end
			end
			S_DEL_FIX_RD: begin
				mem_raddr = up_q[AW-1:0];
			end
			S_DEL_FIX_WR: begin
				mem_we    = 1'b1;
				mem_waddr = up_q[AW-1:0];
				w_par     = r_par;
				w_cnt     = (rd_cnt != '0) ? KW'(rd_cnt - 1'b1) : rd_cnt;
				w_dat     = rd_dat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			used_q        <= '0;
			kind_q        <= ptt_pkg::KIND_ADD;
			idx_q         <= '0;
			pay_q         <= '0;
			base_q        <= '0;
			rd_ptr_q      <= '0;
			pend_q        <= 1'b0;
			pend_addr_q   <= '0;
			up_q          <= '0;
			span_q        <= '0;
			hold_status_q <= ptt_pkg::STATUS_OK;
			hold_pos_q    <= '0;
			hold_par_q    <= '0;
			hold_cnt_q    <= '0;
			hold_dat_q    <= '0;
			res_valid     <= 1'b0;
			status_q      <= ptt_pkg::STATUS_OK;
			position      <= '0;
			parent_index  <= '0;
			child_count   <= '0;
			entry_data    <= '0;
			node_count    <= '0;
		end else begin
			if (res_valid && !res_stall && state_q != S_FINISH) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q  <= ptt_pkg::kind_t'(kind);
						idx_q   <= index;
						pay_q   <= pay_x[DATA_WIDTH-1:0];
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					hold_status_q <= dec_status;
					hold_pos_q    <= dec_pos;
					hold_par_q    <= '0;
					hold_cnt_q    <= '0;
					hold_dat_q    <= '0;
					base_q        <= AW'(idx_q);
					pend_q        <= 1'b0;
					state_q       <= dec_state;
					unique case (kind_q)
						ptt_pkg::KIND_ADD: begin
							if (used_q == '0) begin
								used_q <= CW'(1);
							end else if (dec_state == S_ADD_SHIFT) begin
								rd_ptr_q <= used_q - 1'b1;
							end
						end
						ptt_pkg::KIND_DELETE: begin
							if (idx_q == '0) begin
								used_q <= '0;
							end
						end
						default: begin
						end
					endcase
				end
				S_ADD_SHIFT: begin
					if (add_more) begin
						pend_q      <= 1'b1;
						pend_addr_q <= rd_ptr_q;
						rd_ptr_q    <= rd_ptr_q - 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= S_ADD_PARENT;
						end
					end
				end
				S_ADD_PARENT: begin
					state_q <= S_ADD_NEW;
				end
				S_ADD_NEW: begin
					used_q     <= used_q + 1'b1;
					hold_pos_q <= IW'(base_inc);
					state_q    <= S_FINISH;
				end
				S_DEL_HEAD: begin
					up_q     <= rd_par;
					rd_ptr_q <= CW'(base_q) + 1'b1;
					state_q  <= S_DEL_SCAN;
				end
				S_DEL_SCAN: begin
					if (scan_found) begin
						span_q   <= pend_addr_q - CW'(base_q);
						rd_ptr_q <= pend_addr_q;
						pend_q   <= 1'b0;
						state_q  <= S_DEL_MOVE;
					end else if (fwd_more) begin
						pend_q      <= 1'b1;
						pend_addr_q <= rd_ptr_q;
						rd_ptr_q    <= rd_ptr_q + 1'b1;
					end else begin
						span_q   <= used_q - CW'(base_q);
						rd_ptr_q <= used_q;
						pend_q   <= 1'b0;
						state_q  <= S_DEL_MOVE;
					end
				end
				S_DEL_MOVE: begin
					if (fwd_more) begin
						pend_q      <= 1'b1;
						pend_addr_q <= rd_ptr_q;
						rd_ptr_q    <= rd_ptr_q + 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							used_q  <= used_q - span_q;
							state_q <= S_DEL_FIX_RD;
						end
					end
				end
				S_DEL_FIX_RD: begin
					state_q <= up_ok ? S_DEL_FIX_WR : S_FINISH;
				end
				S_DEL_FIX_WR: begin
					state_q <= S_FINISH;
				end
				S_READ_WAIT: begin
					hold_par_q <= rd_par_x[OPW-1:0];
					hold_cnt_q <= rd_cnt;
					hold_dat_q <= rd_dat_x[ptt_pkg::DATA_W-1:0];
					state_q    <= S_FINISH;
				end
				S_FINISH: begin
					if (!res_valid || !res_stall) begin
						res_valid    <= 1'b1;
						status_q     <= hold_status_q;
						position     <= hold_pos_q;
						parent_index <= hold_par_q;
						child_count  <= hold_cnt_q;
						entry_data   <= hold_dat_q;
						node_count   <= NW'(used_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(CAPACITY))
		else $error("used count above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while previous one in flight");

	a_move_no_alias: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == S_ADD_SHIFT || state_q == S_DEL_MOVE))
			|-> (mem_waddr != mem_raddr))
		else $error("entry move reads the entry being written");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == S_FINISH))
		else $error("result loaded outside finish state");

endmodule

// ===== hdl/ptt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
